[rtl/ptins_pkg.sv]
// Shared types and constants for the four-level page table insert unit.
`default_nettype none
package ptins_pkg;

    localparam int POOL_PAGES_DEF = 16;
    localparam int IDX_W          = 9;
    localparam int PN_W           = 40;
    localparam int VA_W           = 48;
    localparam int PA_W           = 52;
    localparam int MOD_BITS       = 4;
    localparam int MOD_STEPS      = PN_W / MOD_BITS;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_MISALIGNED = 3'd1;
    localparam logic [2:0] ST_EXHAUSTED  = 3'd2;
    localparam logic [2:0] ST_LARGE      = 3'd3;
    localparam logic [2:0] ST_MAPPED     = 3'd4;

    localparam logic [1:0] LVL_ROOT = 2'd0;
    localparam logic [1:0] LVL_LEAF = 2'd3;

    typedef struct packed {
        logic [VA_W-1:0] virt_addr;
        logic [PA_W-1:0] phys_addr;
        logic            leaf_present;
        logic            leaf_writable;
        logic            leaf_user;
        logic            leaf_write_through;
        logic            leaf_cache_disable;
        logic            leaf_no_execute;
    } t_in;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] pages_in_use;
    } t_out;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_MOD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       clr_wr;
        logic       accept;
        logic       rd;
        logic       alloc;
        logic       leaf;
        logic       mod_load;
        logic       mod_step;
        logic       descend;
        logic       set_st;
        logic [2:0] st_code;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic       clr_last;
        logic       misaligned;
        logic       present;
        logic       large_pg;
        logic       pool_full;
        logic       mod_last;
        logic       out_busy;
        logic [1:0] level;
    } t_sts;

endpackage
`default_nettype wire

[rtl/ptins_ctrl.sv]
// Controller state machine for the page table insert unit.
`default_nettype none
module ptins_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire ptins_pkg::t_sts i_sts,
    output ptins_pkg::t_cmd      o_cmd,
    output logic                 o_in_ready
);
    import ptins_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = i_sts.misaligned ? S_DONE : S_READ;
            end
            S_READ: n_state = S_EVAL;
            S_EVAL: begin
                if (i_sts.level == LVL_LEAF) begin
                    n_state = S_DONE;
                end else if (i_sts.present) begin
                    if (i_sts.level != LVL_ROOT && i_sts.large_pg) n_state = S_DONE;
                    else n_state = S_MOD;
                end else if (i_sts.pool_full) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_MOD: begin
                if (i_sts.mod_last) n_state = S_READ;
            end
            S_DONE: begin
                if (!i_sts.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: o_cmd.clr_wr = 1'b1;
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.accept   = i_in_valid;
                o_cmd.set_st   = i_in_valid;
                o_cmd.st_code  = i_sts.misaligned ? ST_MISALIGNED : ST_OK;
            end
            S_READ: o_cmd.rd = 1'b1;
            S_EVAL: begin
                if (i_sts.level == LVL_LEAF) begin
                    o_cmd.set_st  = 1'b1;
                    o_cmd.st_code = i_sts.present ? ST_MAPPED : ST_OK;
                    o_cmd.leaf    = !i_sts.present;
                end else if (i_sts.present) begin
                    if (i_sts.level != LVL_ROOT && i_sts.large_pg) begin
                        o_cmd.set_st  = 1'b1;
                        o_cmd.st_code = ST_LARGE;
                    end else begin
                        o_cmd.mod_load = 1'b1;
                    end
                end else if (i_sts.pool_full) begin
                    o_cmd.set_st  = 1'b1;
                    o_cmd.st_code = ST_EXHAUSTED;
                end else begin
                    o_cmd.alloc = 1'b1;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                o_cmd.descend  = i_sts.mod_last;
            end
            S_DONE: o_cmd.finish = !i_sts.out_busy;
            default: o_cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

[rtl/ptins_dpath.sv]
// Datapath of the page table insert unit: table store, walk registers, page reducer.
`default_nettype none
module ptins_dpath #(
    parameter int POOL_PAGES = ptins_pkg::POOL_PAGES_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire ptins_pkg::t_cmd          i_cmd,
    input  wire ptins_pkg::t_in           i_in,
    input  wire logic                     i_cfg_valid,
    input  wire logic [ptins_pkg::PN_W-1:0] i_cfg_data,
    input  wire logic                     i_out_ready,
    output ptins_pkg::t_sts               o_sts,
    output logic                          o_out_valid,
    output ptins_pkg::t_out               o_out
);
    import ptins_pkg::*;

    localparam int PW    = $clog2(POOL_PAGES);
    localparam int AW    = PW + IDX_W;
    localparam int DEPTH = POOL_PAGES * (1 << IDX_W);
    localparam int CW    = ($clog2(POOL_PAGES + 1) > 5) ? $clog2(POOL_PAGES + 1) : 5;
    localparam int RW    = PW + 1;
    localparam int MCW   = $clog2(MOD_STEPS);

    logic [64:0]        mem [DEPTH];
    logic [64:0]        r_rd;
    t_in                r_item;
    logic [PW-1:0]      r_page;
    logic [1:0]         r_level;
    logic [CW-1:0]      r_nfp;
    logic [PN_W-1:0]    r_base;
    logic [2:0]         r_status;
    logic [AW-1:0]      r_clr;
    logic [PN_W-1:0]    r_off;
    logic [RW-1:0]      r_rem;
    logic [MCW-1:0]     r_mcnt;
    logic               r_out_valid;
    t_out               r_out;

    logic [IDX_W-1:0]   idx;
    logic [AW-1:0]      addr;
    logic               alloc_cur;
    logic [63:0]        entry;
    logic [PN_W-1:0]    new_pn;
    logic [64:0]        wdata;
    logic               we;
    logic [RW-1:0]      rem_nxt;

    always_comb begin
        case (r_level)
            2'd0:    idx = r_item.virt_addr[47:39];
            2'd1:    idx = r_item.virt_addr[38:30];
            2'd2:    idx = r_item.virt_addr[29:21];
            default: idx = r_item.virt_addr[20:12];
        endcase
    end

    assign addr      = i_cmd.clr_wr ? r_clr : {r_page, idx};
    assign alloc_cur = CW'(r_page) < r_nfp;
    assign entry     = (r_rd[64] == alloc_cur) ? r_rd[63:0] : 64'd0;
    assign new_pn    = r_base + PN_W'(r_nfp);

    always_comb begin
        we    = i_cmd.clr_wr | i_cmd.alloc | i_cmd.leaf;
        wdata = '0;
        if (i_cmd.alloc) begin
            wdata = {CW'(r_page) <= r_nfp, 12'd0, new_pn, 12'h003};
        end else if (i_cmd.leaf) begin
            wdata = {alloc_cur, r_item.leaf_no_execute, 11'd0,
                     r_item.phys_addr[51:12], 7'd0,
                     r_item.leaf_cache_disable, r_item.leaf_write_through,
                     r_item.leaf_user, r_item.leaf_writable, r_item.leaf_present};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[addr] <= wdata;
        if (i_cmd.rd) r_rd <= mem[addr];
    end

    always_comb begin
        logic [RW-1:0] rem;
        rem = r_rem;
        for (int k = 0; k < MOD_BITS; k++) begin
            rem = {rem[RW-2:0], r_off[PN_W-1-k]};
            if (rem >= RW'(POOL_PAGES)) rem = rem - RW'(POOL_PAGES);
        end
        rem_nxt = rem;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_item <= i_in;
        if (i_cmd.set_st) r_status <= i_cmd.st_code;
        if (i_cmd.mod_load) begin
            r_off  <= entry[51:12] - r_base;
            r_rem  <= '0;
            r_mcnt <= '0;
        end else if (i_cmd.mod_step) begin
            r_off  <= {r_off[PN_W-MOD_BITS-1:0], {MOD_BITS{1'b0}}};
            r_rem  <= rem_nxt;
            r_mcnt <= r_mcnt + 1'b1;
        end
        if (i_cmd.finish) r_out <= '{status: r_status, pages_in_use: r_nfp[4:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nfp       <= CW'(1);
            r_base      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_page      <= '0;
            r_level     <= '0;
        end else begin
            if (i_cfg_valid) r_base <= i_cfg_data;
            if (i_cmd.clr_wr) r_clr <= r_clr + 1'b1;
            if (i_cmd.accept) begin
                r_page  <= '0;
                r_level <= '0;
            end else if (i_cmd.alloc) begin
                r_page  <= r_nfp[PW-1:0];
                r_nfp   <= r_nfp + 1'b1;
                r_level <= r_level + 1'b1;
            end else if (i_cmd.descend) begin
                r_page  <= rem_nxt[PW-1:0];
                r_level <= r_level + 1'b1;
            end
            if (i_cmd.finish) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_sts.clr_last   = r_clr == AW'(DEPTH - 1);
    assign o_sts.misaligned = (|i_in.virt_addr[11:0]) | (|i_in.phys_addr[11:0]);
    assign o_sts.present    = entry[0];
    assign o_sts.large_pg   = entry[7];
    assign o_sts.pool_full  = r_nfp >= CW'(POOL_PAGES);
    assign o_sts.mod_last   = r_mcnt == MCW'(MOD_STEPS - 1);
    assign o_sts.out_busy   = r_out_valid & ~i_out_ready;
    assign o_sts.level      = r_level;
    assign o_out_valid      = r_out_valid;
    assign o_out            = r_out;
endmodule
`default_nettype wire

[rtl/four_level_page_table_insert_unit.sv]
// Top level of the four-level page table insert unit.
// After reset the unit sweeps all POOL_PAGES*512 entries of its table store (8192 at the
// default), one entry per cycle, and takes no request until the sweep ends; the base register
// may be written at any time. A misaligned request goes from acceptance straight to posting
// its result; otherwise the unit accepts the request, reads and then evaluates one entry for
// each level visited through the single-port table store, and for each level that follows an
// existing entry reduces the page number less the base modulo POOL_PAGES four bits a cycle,
// before it posts the result. One request is in flight at a time; a finished request waits
// while the previous result is still unaccepted.
`default_nettype none
module four_level_page_table_insert_unit #(
    parameter int POOL_PAGES = ptins_pkg::POOL_PAGES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire ptins_pkg::t_in            i_in,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output ptins_pkg::t_out                o_out,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [ptins_pkg::PN_W-1:0] i_cfg_data
);
    import ptins_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    ptins_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    ptins_dpath #(
        .POOL_PAGES (POOL_PAGES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );
endmodule
`default_nettype wire
